FILE: sv/mbwf_pkg.sv
// Shared types and constants for the write-single-register frame builder.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package mbwf_pkg;

  // Command codes on the input channel (code 3 carries no meaning)
  typedef enum logic [1:0] {
    CMD_RUN      = 2'd0,
    CMD_STOP     = 2'd1,
    CMD_SET_FREQ = 2'd2
  } cmd_t;

  // Configuration register indexes
  localparam logic [7:0] CFG_SLAVE_ADDRESS      = 8'd0;
  localparam logic [7:0] CFG_FREQUENCY_LIMIT    = 8'd1;
  localparam logic [7:0] CFG_CONTROL_REGISTER   = 8'd2;
  localparam logic [7:0] CFG_FREQUENCY_REGISTER = 8'd3;

  // Configuration reset values
  localparam logic [7:0]  RST_SLAVE_ADDRESS      = 8'd1;
  localparam logic [15:0] RST_FREQUENCY_LIMIT    = 16'd7000;
  localparam logic [15:0] RST_CONTROL_REGISTER   = 16'd9473;
  localparam logic [15:0] RST_FREQUENCY_REGISTER = 16'd9474;

  // Frame constants
  localparam logic [7:0]  FUNC_WRITE_SINGLE = 8'h06;
  localparam logic [15:0] CRC_POLY          = 16'hA001;
  localparam logic [15:0] CRC_INIT          = 16'hFFFF;
  localparam logic [15:0] DATA_RUN          = 16'd1;
  localparam logic [15:0] DATA_STOP         = 16'd0;

  // Byte positions within a frame
  localparam logic [2:0] POS_SLAVE    = 3'd0;
  localparam logic [2:0] POS_FUNC     = 3'd1;
  localparam logic [2:0] POS_REG_HI   = 3'd2;
  localparam logic [2:0] POS_REG_LO   = 3'd3;
  localparam logic [2:0] POS_DATA_HI  = 3'd4;
  localparam logic [2:0] POS_DATA_LO  = 3'd5;
  localparam logic [2:0] POS_CRC_LO   = 3'd6;
  localparam logic [2:0] POS_CRC_HI   = 3'd7;

  // One classified command, as queued between front and back
  typedef struct packed {
    logic        rejected;
    logic [7:0]  slave_addr;
    logic [15:0] reg_addr;
    logic [15:0] data;
  } frame_desc_t;

endpackage

`default_nettype wire

FILE: sv/mbwf_front.sv
// Front end: configuration registers, command acceptance and classification.
// Depends on mbwf_pkg; pushes frame descriptors into mbwf_queue.
`default_nettype none

module mbwf_front import mbwf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  // command channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [15:0] in_frequency,
  // queue push side
  output logic             push_valid,
  input  wire logic        push_ready,
  output frame_desc_t      push_desc
);

  logic [7:0]  slave_address_r;
  logic [15:0] frequency_limit_r;
  logic [15:0] control_register_r;
  logic [15:0] frequency_register_r;

  // Accept every configuration transfer; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_address_r      <= RST_SLAVE_ADDRESS;
      frequency_limit_r    <= RST_FREQUENCY_LIMIT;
      control_register_r   <= RST_CONTROL_REGISTER;
      frequency_register_r <= RST_FREQUENCY_REGISTER;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SLAVE_ADDRESS:      slave_address_r      <= cfg_data[7:0];
        CFG_FREQUENCY_LIMIT:    frequency_limit_r    <= cfg_data;
        CFG_CONTROL_REGISTER:   control_register_r   <= cfg_data;
        CFG_FREQUENCY_REGISTER: frequency_register_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Classify the command; an undefined code is taken and dropped
  assign in_ready = push_ready;

  always_comb begin
    push_desc            = '0;
    push_desc.slave_addr = slave_address_r;
    push_valid           = in_valid;
    case (cmd_t'(in_cmd))
      CMD_RUN: begin
        push_desc.reg_addr = control_register_r;
        push_desc.data     = DATA_RUN;
      end
      CMD_STOP: begin
        push_desc.reg_addr = control_register_r;
        push_desc.data     = DATA_STOP;
      end
      CMD_SET_FREQ: begin
        push_desc.reg_addr = frequency_register_r;
        push_desc.data     = in_frequency;
        push_desc.rejected = (in_frequency > frequency_limit_r);
      end
      default: begin
        push_valid = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/mbwf_queue.sv
// Short descriptor queue between front and back ends.
// Depends on mbwf_pkg for the descriptor type.
`default_nettype none

module mbwf_queue import mbwf_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push_valid,
  output logic             push_ready,
  input  wire frame_desc_t push_desc,
  output logic             pop_valid,
  input  wire logic        pop_ready,
  output frame_desc_t      pop_desc
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  frame_desc_t      mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push, pop;

  assign push_ready = (count_r != CNT_FULL);
  assign pop_valid  = (count_r != '0);
  assign pop_desc   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Advance pointers with wrap, track occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

`default_nettype wire

FILE: sv/mbwf_back.sv
// Back end: walks one descriptor byte by byte, folds the CRC in as it goes,
// and drives the registered result channel. Depends on mbwf_pkg.
`default_nettype none

module mbwf_back import mbwf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // queue pop side
  input  wire logic        desc_valid,
  output logic             desc_pop,
  input  wire frame_desc_t desc,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_frame_byte,
  output logic             out_last_byte,
  output logic             out_rejected
);

  // CRC-16 update over one byte, LSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic        last_r, last_nxt;
  logic        rej_r, rej_nxt;
  logic [2:0]  pos_r, pos_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [15:0] crc_cur;
  logic        load, fire;

  assign out_valid      = out_valid_r;
  assign out_frame_byte = byte_r;
  assign out_last_byte  = last_r;
  assign out_rejected   = rej_r;

  // Pick the next byte (one zero byte for a rejection), advance position, update CRC over all non-CRC bytes
  always_comb begin
    load          = !out_valid_r || out_ready;
    fire          = load && desc_valid;
    crc_cur       = (pos_r == POS_SLAVE) ? CRC_INIT : crc_r;
    byte_nxt      = byte_r;
    last_nxt      = last_r;
    rej_nxt       = rej_r;
    pos_nxt       = pos_r;
    crc_nxt       = crc_r;
    desc_pop      = 1'b0;
    out_valid_nxt = load ? 1'b0 : out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
      if (desc.rejected) begin
        byte_nxt = 8'h00;
        last_nxt = 1'b1;
        rej_nxt  = 1'b1;
        desc_pop = 1'b1;
      end else begin
        case (pos_r)
          POS_SLAVE:   byte_nxt = desc.slave_addr;
          POS_FUNC:    byte_nxt = FUNC_WRITE_SINGLE;
          POS_REG_HI:  byte_nxt = desc.reg_addr[15:8];
          POS_REG_LO:  byte_nxt = desc.reg_addr[7:0];
          POS_DATA_HI: byte_nxt = desc.data[15:8];
          POS_DATA_LO: byte_nxt = desc.data[7:0];
          POS_CRC_LO:  byte_nxt = crc_r[7:0];
          POS_CRC_HI:  byte_nxt = crc_r[15:8];
          default:     byte_nxt = 8'h00;
        endcase
        if (pos_r != POS_CRC_LO && pos_r != POS_CRC_HI) begin
          crc_nxt = crc_byte(crc_cur, byte_nxt);
        end
        rej_nxt  = 1'b0;
        last_nxt = (pos_r == POS_CRC_HI);
        desc_pop = (pos_r == POS_CRC_HI);
        pos_nxt  = (pos_r == POS_CRC_HI) ? POS_SLAVE : pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pos_r       <= POS_SLAVE;
    end else begin
      out_valid_r <= out_valid_nxt;
      pos_r       <= pos_nxt;
    end
  end

  // Payload holds without reset
  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    last_r <= last_nxt;
    rej_r  <= rej_nxt;
    crc_r  <= crc_nxt;
  end

endmodule

`default_nettype wire

FILE: sv/modbus_write_register_framer_top.sv
// Top level of the write-single-register frame builder with CRC-16.
// Depends on mbwf_pkg, mbwf_front, mbwf_queue and mbwf_back.
//
//   channel  direction  handshake              payload
//   cfg      in         cfg_valid / cfg_ready  cfg_index[7:0], cfg_data[15:0]
//   in       in         in_valid / in_ready    in_cmd[1:0], in_frequency[15:0]
//   out      out        out_valid / out_ready  out_frame_byte[7:0], out_last_byte, out_rejected
//
// A frame leaves as eight transfers, one per cycle while out_ready stays high; a rejected
// command leaves as a single transfer. The byte sequencer in mbwf_back sets the byte order.
// The queue holds QUEUE_DEPTH commands, the one whose frame is being sent included.
// Synchronous active-low reset restores register defaults and empties the queue.
// Either side may stall at any time; the output register holds its transfer.
`default_nettype none

module modbus_write_register_framer_top import mbwf_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [15:0] in_frequency,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_frame_byte,
  output logic             out_last_byte,
  output logic             out_rejected
);

  logic        push_valid, push_ready;
  frame_desc_t push_desc;
  logic        pop_valid, pop_ready;
  frame_desc_t pop_desc;

  mbwf_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cmd       (in_cmd),
    .in_frequency (in_frequency),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_desc    (push_desc)
  );

  mbwf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_desc  (push_desc),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_desc   (pop_desc)
  );

  mbwf_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .desc_valid     (pop_valid),
    .desc_pop       (pop_ready),
    .desc           (pop_desc),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_frame_byte (out_frame_byte),
    .out_last_byte  (out_last_byte),
    .out_rejected   (out_rejected)
  );

endmodule

`default_nettype wire
